FILE: sv/brcf_pkg.sv
`timescale 1ns / 1ps

package brcf_pkg;

    // Default geometry of the ring.
    localparam int CAPACITY     = 1024;
    localparam int MAX_TRANSFER = 64;

    // Fixed widths of the result fields.
    localparam int COUNT_W = 7;
    localparam int FILL_W  = 11;

    typedef enum logic
    {
        FUNC_WRITE = 1'b0,
        FUNC_READ  = 1'b1
    } func_t;

    typedef enum logic
    {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_OK       = 2'd0,
        ST_OVERSIZE = 2'd1,
        ST_NOSPACE  = 2'd2,
        ST_NODATA   = 2'd3
    } status_t;

    // One result word as it travels toward the output.
    typedef struct packed
    {
        kind_t               kind;
        logic [7:0]          data_byte_res;
        status_t             status;
        logic [COUNT_W-1:0]  count;
        logic [FILL_W-1:0]   fill_level;
        logic                last;
    } result_t;

    // A result issued by the controller; data words pick up their byte from
    // the store in the next cycle.
    typedef struct packed
    {
        logic    valid;
        result_t meta;
    } issue_t;

endpackage

FILE: sv/brcf_req_if.sv
`timescale 1ns / 1ps

interface brcf_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;
    logic [7:0] length;

    modport source
    (
        output valid,
        output func,
        output data_byte,
        output length,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  func,
        input  data_byte,
        input  length,
        output ready
    );
endinterface

FILE: sv/brcf_rsp_if.sv
`timescale 1ns / 1ps

interface brcf_rsp_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte_res;
    logic [1:0]  status;
    logic [6:0]  count;
    logic [10:0] fill_level;
    logic        last;

    modport source
    (
        output valid,
        output kind,
        output data_byte_res,
        output status,
        output count,
        output fill_level,
        output last,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  kind,
        input  data_byte_res,
        input  status,
        input  count,
        input  fill_level,
        input  last,
        output ready
    );
endinterface

FILE: sv/byte_ring_chunk_fifo_top.sv
`timescale 1ns / 1ps

// Byte ring that stores and delivers whole chunks, all or nothing. A write
// byte word is taken whenever the request channel is ready; an admitted read
// delivers one byte per cycle while the output side has room and holds the
// request channel until its last byte is issued, paced by the single read
// port of the byte store. Each issued result passes the output stage, where
// a data word meets the store's read data, then waits in a two-word queue
// while the result channel stalls. Writes of a chunk are staged past the
// committed write pointer and become visible with the chunk's status word.
// The store needs no clearing after reset: only written bytes are read.
module byte_ring_chunk_fifo_top #(
    parameter int CAPACITY     = brcf_pkg::CAPACITY,
    parameter int MAX_TRANSFER = brcf_pkg::MAX_TRANSFER,
    localparam int AW          = $clog2(CAPACITY)
) (
    input  logic        clk,
    input  logic        rst_n,
    brcf_req_if.sink    req,
    brcf_rsp_if.source  rsp
);

    brcf_pkg::issue_t issue;
    logic             can_issue;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [7:0]       mem_rdata;

    brcf_ctrl #(
        .CAPACITY     (CAPACITY),
        .MAX_TRANSFER (MAX_TRANSFER)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .can_issue (can_issue),
        .issue     (issue),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr)
    );

    brcf_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    brcf_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .rdata     (mem_rdata),
        .can_issue (can_issue),
        .rsp       (rsp)
    );

    // A result word is only issued when the output side has room for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid |-> can_issue)
        else $error("result issued without output room");

    // The store is never written and read in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("store written and read in the same cycle");

    // No request word is taken while a read is streaming.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> !req.ready)
        else $error("request accepted during read streaming");

    // A store read always yields a data word in the output stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (issue.valid && issue.meta.kind == brcf_pkg::KIND_DATA))
        else $error("store read without a data word");

endmodule

FILE: sv/brcf_store.sv
`timescale 1ns / 1ps

// Byte store: one write port and one read port, read data registered.
module brcf_store #(
    parameter int CAPACITY = brcf_pkg::CAPACITY,
    localparam int AW      = $clog2(CAPACITY)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [CAPACITY];
    logic [7:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/brcf_ctrl.sv
`timescale 1ns / 1ps

// Chunk and read sequencer: owns the pointers and fill level, drives the
// store ports and issues one result word per cycle at most.
module brcf_ctrl #(
    parameter int CAPACITY     = brcf_pkg::CAPACITY,
    parameter int MAX_TRANSFER = brcf_pkg::MAX_TRANSFER,
    localparam int AW          = $clog2(CAPACITY),
    localparam int FW          = $clog2(CAPACITY + 1),
    localparam int CW          = (FW > 8) ? FW : 8
) (
    input  logic             clk,
    input  logic             rst_n,
    brcf_req_if.sink         req,
    input  logic             can_issue,
    output brcf_pkg::issue_t issue,
    output logic             mem_we,
    output logic [AW-1:0]    mem_waddr,
    output logic [7:0]       mem_wdata,
    output logic             mem_re,
    output logic [AW-1:0]    mem_raddr
);

    logic [AW-1:0]       wp_reg, wp_next;
    logic [AW-1:0]       wa_reg, wa_next;
    logic [AW-1:0]       ra_reg, ra_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [7:0]          left_reg, left_next;
    logic [7:0]          len_held_reg, len_held_next;
    brcf_pkg::status_t   st_held_reg, st_held_next;
    logic                busy_reg, busy_next;
    logic [6:0]          rd_left_reg, rd_left_next;
    logic [6:0]          rd_len_reg, rd_len_next;

    logic                accept;
    logic                start;
    brcf_pkg::status_t   st_check;
    brcf_pkg::status_t   st_eff;
    logic [7:0]          len_eff;
    logic [7:0]          left_eff;
    logic [AW-1:0]       addr_eff;
    logic [FW-1:0]       fill_add;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(CAPACITY - 1)) ? '0 : a + 1'b1;
    endfunction

    assign req.ready = !busy_reg && can_issue;
    assign accept    = req.valid && req.ready;

    // Chunk admission check: oversize wins over lack of space.
    always_comb
    begin
        priority if (CW'(req.length) > CW'(MAX_TRANSFER))
        begin
            st_check = brcf_pkg::ST_OVERSIZE;
        end
        else if (CW'(req.length) > CW'(CAPACITY) - CW'(fill_reg))
        begin
            st_check = brcf_pkg::ST_NOSPACE;
        end
        else
        begin
            st_check = brcf_pkg::ST_OK;
        end
    end

    // Chunk context: taken from the item on a chunk's first byte.
    assign start    = (left_reg == 8'd0);
    assign st_eff   = start ? st_check : st_held_reg;
    assign len_eff  = start ? req.length : len_held_reg;
    assign left_eff = start ? req.length : left_reg;
    assign addr_eff = start ? wp_reg : wa_reg;
    assign fill_add = fill_reg + FW'(len_eff);

    // Sequencing of writes, read admission and read streaming.
    always_comb
    begin
        wp_next       = wp_reg;
        wa_next       = wa_reg;
        ra_next       = ra_reg;
        fill_next     = fill_reg;
        left_next     = left_reg;
        len_held_next = len_held_reg;
        st_held_next  = st_held_reg;
        busy_next     = busy_reg;
        rd_left_next  = rd_left_reg;
        rd_len_next   = rd_len_reg;

        issue.valid              = 1'b0;
        issue.meta.kind          = brcf_pkg::KIND_STATUS;
        issue.meta.data_byte_res = 8'd0;
        issue.meta.status        = brcf_pkg::ST_OK;
        issue.meta.count         = '0;
        issue.meta.fill_level    = brcf_pkg::FILL_W'(fill_reg);
        issue.meta.last          = 1'b1;

        mem_we    = 1'b0;
        mem_waddr = addr_eff;
        mem_wdata = req.data_byte;
        mem_re    = 1'b0;
        mem_raddr = ra_reg;

        if (busy_reg)
        begin
            // Stream one byte of an admitted read per cycle while the output side has room.
            if (can_issue)
            begin
                mem_re          = 1'b1;
                issue.valid     = 1'b1;
                issue.meta.kind = brcf_pkg::KIND_DATA;
                issue.meta.count = rd_len_reg;
                issue.meta.last = (rd_left_reg == 7'd1);
                ra_next         = wrap_inc(ra_reg);
                rd_left_next    = rd_left_reg - 7'd1;
                if (rd_left_reg == 7'd1)
                begin
                    busy_next = 1'b0;
                end
            end
        end
        else if (accept)
        begin
            if (req.func == brcf_pkg::FUNC_WRITE)
            begin
                if (start && (req.length == 8'd0))
                begin
                    issue.valid = 1'b1;
                end
                else
                begin
                    // Stage accepted bytes past the committed write pointer.
                    if (st_eff == brcf_pkg::ST_OK)
                    begin
                        mem_we  = 1'b1;
                        wa_next = wrap_inc(addr_eff);
                    end
                    left_next     = left_eff - 8'd1;
                    st_held_next  = st_eff;
                    len_held_next = len_eff;
                    if (left_eff == 8'd1)
                    begin
                        issue.valid       = 1'b1;
                        issue.meta.status = st_eff;
                        if (st_eff == brcf_pkg::ST_OK)
                        begin
                            issue.meta.count      = len_eff[6:0];
                            issue.meta.fill_level = brcf_pkg::FILL_W'(fill_add);
                            fill_next             = fill_add;
                            wp_next               = wrap_inc(addr_eff);
                        end
                    end
                end
            end
            else
            begin
                priority if (req.length == 8'd0)
                begin
                    issue.valid = 1'b1;
                end
                else if (CW'(req.length) > CW'(MAX_TRANSFER))
                begin
                    issue.valid       = 1'b1;
                    issue.meta.status = brcf_pkg::ST_OVERSIZE;
                end
                else if (CW'(req.length) > CW'(fill_reg))
                begin
                    issue.valid       = 1'b1;
                    issue.meta.status = brcf_pkg::ST_NODATA;
                end
                else
                begin
                    // Bytes leave the fill level now; no write can follow
                    // until the last of them has been read.
                    busy_next    = 1'b1;
                    rd_left_next = req.length[6:0];
                    rd_len_next  = req.length[6:0];
                    fill_next    = fill_reg - FW'(req.length);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            wa_reg       <= '0;
            ra_reg       <= '0;
            fill_reg     <= '0;
            left_reg     <= 8'd0;
            len_held_reg <= 8'd0;
            st_held_reg  <= brcf_pkg::ST_OK;
            busy_reg     <= 1'b0;
            rd_left_reg  <= 7'd0;
            rd_len_reg   <= 7'd0;
        end
        else
        begin
            wp_reg       <= wp_next;
            wa_reg       <= wa_next;
            ra_reg       <= ra_next;
            fill_reg     <= fill_next;
            left_reg     <= left_next;
            len_held_reg <= len_held_next;
            st_held_reg  <= st_held_next;
            busy_reg     <= busy_next;
            rd_left_reg  <= rd_left_next;
            rd_len_reg   <= rd_len_next;
        end
    end

endmodule

FILE: sv/brcf_outq.sv
`timescale 1ns / 1ps

// Output side: one stage that meets the store's read data, then a two-word
// queue that absorbs stalls on the result channel.
module brcf_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  brcf_pkg::issue_t issue,
    input  logic [7:0]       rdata,
    output logic             can_issue,
    brcf_rsp_if.source       rsp
);

    logic               s1_valid_reg;
    brcf_pkg::result_t  s1_meta_reg;
    brcf_pkg::result_t  s1_word;
    brcf_pkg::result_t  q_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         cnt_reg, cnt_next;
    logic               pop;
    brcf_pkg::result_t  head;

    // Data words take their byte from the store read port.
    always_comb
    begin
        s1_word = s1_meta_reg;
        if (s1_meta_reg.kind == brcf_pkg::KIND_DATA)
        begin
            s1_word.data_byte_res = rdata;
        end
    end

    assign pop = rsp.valid && rsp.ready;

    // Room for a word issued now once it reaches the queue.
    assign can_issue = (3'(cnt_reg) + 3'(s1_valid_reg) - 3'(pop)) < 3'd2;
    assign cnt_next  = cnt_reg + 2'(s1_valid_reg) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            s1_valid_reg <= issue.valid;
            cnt_reg      <= cnt_next;
            if (s1_valid_reg)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            s1_meta_reg <= issue.meta;
        end
        if (s1_valid_reg)
        begin
            q_reg[wr_ptr_reg] <= s1_word;
        end
    end

    assign head              = q_reg[rd_ptr_reg];
    assign rsp.valid         = (cnt_reg != 2'd0);
    assign rsp.kind          = head.kind;
    assign rsp.data_byte_res = head.data_byte_res;
    assign rsp.status        = head.status;
    assign rsp.count         = head.count;
    assign rsp.fill_level    = head.fill_level;
    assign rsp.last          = head.last;

endmodule
